// ===== hw/rtl/assert_macros.svh =====
// assertion macros shared by the rtl of the f1 score unit
// no dependencies; included by the files that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, checked out of reset
`define MSF1_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication, checked out of reset
`define MSF1_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define MSF1_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define MSF1_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== hw/rtl/msf1_pkg.sv =====
// types and constants of the masked segmentation f1 score unit
// no dependencies; used by every module of the block
package msf1_pkg;

  localparam int COUNT_WIDTH = 25;
  localparam int FRAC_BITS   = 16;
  // remainder of the divider: twice the largest denominator
  localparam int REM_WIDTH   = COUNT_WIDTH + 3;
  localparam int STEP_WIDTH  = $clog2(FRAC_BITS);

  localparam logic [7:0] PIX_FG = 8'd0;
  localparam logic [7:0] PIX_BG = 8'd255;

  typedef struct packed {
    logic [7:0] mask_pixel;
    logic [7:0] result_pixel;
    logic [7:0] target_pixel;
    logic       last_pixel;
  } pixel_t;

  typedef struct packed {
    logic [COUNT_WIDTH-1:0] true_pos;
    logic [COUNT_WIDTH-1:0] false_pos;
    logic [COUNT_WIDTH-1:0] false_neg;
    logic [FRAC_BITS-1:0]   f1_fixed;
  } score_t;

  typedef struct packed {
    logic inc;
    logic clear;
  } count_ctl_t;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_LOAD,
    ST_DIV,
    ST_DONE
  } state_t;

endpackage

// ===== hw/rtl/msf1_counter.sv =====
// saturating tp / fp / fn counters fed by the pixel stream
// depends on msf1_pkg and assert_macros.svh
`include "assert_macros.svh"
module msf1_counter
  import msf1_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  count_ctl_t             ctl,
  input  logic [7:0]             result_pixel,
  input  logic [7:0]             target_pixel,
  output logic [COUNT_WIDTH-1:0] tp,
  output logic [COUNT_WIDTH-1:0] fp,
  output logic [COUNT_WIDTH-1:0] fn
);

  localparam logic [COUNT_WIDTH-1:0] CNT_FULL = {COUNT_WIDTH{1'b1}};
  localparam logic [COUNT_WIDTH-1:0] CNT_ONE  = COUNT_WIDTH'(1);

  logic is_tp, is_fp, is_fn;

  assign is_tp = (result_pixel == PIX_FG) && (target_pixel == PIX_FG);
  assign is_fp = (result_pixel == PIX_FG) && (target_pixel == PIX_BG);
  assign is_fn = (result_pixel == PIX_BG) && (target_pixel == PIX_FG);

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      tp <= '0;
      fp <= '0;
      fn <= '0;
    end else if (ctl.inc) begin
      if (is_tp && tp != CNT_FULL) tp <= tp + CNT_ONE;
      if (is_fp && fp != CNT_FULL) fp <= fp + CNT_ONE;
      if (is_fn && fn != CNT_FULL) fn <= fn + CNT_ONE;
    end
  end

  `MSF1_ASSERT_NXT(a_clear_zero, clk, rst, ctl.clear, (tp == '0 && fp == '0 && fn == '0))
  `MSF1_ASSERT_NXT(a_hold_idle, clk, rst, (!ctl.inc && !ctl.clear), ($stable(tp) && $stable(fp) && $stable(fn)))
  `MSF1_ASSERT_IMP(a_one_class, clk, rst, ctl.inc, $onehot0({is_tp, is_fp, is_fn}))

endmodule

// ===== hw/rtl/msf1_divider.sv =====
// restoring fraction divider, one quotient bit per cycle
// depends on msf1_pkg and assert_macros.svh
`include "assert_macros.svh"
module msf1_divider
  import msf1_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [REM_WIDTH-1:0] num,
  input  logic [REM_WIDTH-1:0] den,
  output logic                 done,
  output logic [FRAC_BITS-1:0] quot
);

  localparam logic [STEP_WIDTH-1:0] LAST_STEP = STEP_WIDTH'(FRAC_BITS - 1);

  logic                  busy;
  logic [STEP_WIDTH-1:0] step;
  logic [REM_WIDTH-1:0]  rem;
  logic [REM_WIDTH-1:0]  dvs;
  logic [REM_WIDTH-1:0]  shifted;
  logic                  ge;

  // num < den holds on entry, so the shifted remainder never overflows
  assign shifted = {rem[REM_WIDTH-2:0], 1'b0};
  assign ge      = (shifted >= dvs);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + STEP_WIDTH'(1);
        if (step == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= num;
      dvs  <= den;
      quot <= '0;
    end else if (busy) begin
      rem  <= ge ? (shifted - dvs) : shifted;
      quot <= {quot[FRAC_BITS-2:0], ge};
    end
  end

  `MSF1_ASSERT_IMP(a_rem_below, clk, rst, busy, (rem < dvs))
  `MSF1_ASSERT_IMP(a_done_idle, clk, rst, done, !busy)
  `MSF1_ASSERT_NXT(a_start_busy, clk, rst, start, busy)

endmodule

// ===== hw/rtl/masked_segmentation_f1_score_unit.sv =====
// top level of the masked segmentation f1 score unit
// depends on msf1_pkg, msf1_counter, msf1_divider and assert_macros.svh
//
// Pixels of a frame come in one per cycle while not stalled; a pixel whose mask byte is zero is
// skipped, and result/target bytes of 0 (foreground) and 255 (background) drive three saturating
// counters (true positive, false positive, false negative). The pixel marked last holds the input
// stalled while the block latches the clamped counts and forms 2tp+fp+fn, runs the restoring
// divider that yields one quotient bit per cycle, lets the divider flag done, and writes the score
// register. If the previous score item is still waiting downstream, that last step waits with it.
// The score item holds the clamped counts (each at least 1) and floor(2^FRAC_BITS * 2tp /
// (2tp+fp+fn)); the counters are cleared for the next frame as the divider is started.
`include "assert_macros.svh"
module masked_segmentation_f1_score_unit
  import msf1_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   pixel_valid,
  output logic   pixel_stall,
  input  pixel_t pixel,
  output logic   score_valid,
  input  logic   score_stall,
  output score_t score
);

  localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);

  state_t state;
  state_t state_next;

  logic                   accept;
  logic                   div_start;
  logic                   div_done;
  logic                   out_load;
  count_ctl_t             cnt_ctl;
  logic [COUNT_WIDTH-1:0] tp, fp, fn;
  logic [COUNT_WIDTH-1:0] tp_cl, fp_cl, fn_cl;
  logic [COUNT_WIDTH-1:0] tp_hold, fp_hold, fn_hold;
  logic [REM_WIDTH-1:0]   div_num;
  logic [REM_WIDTH-1:0]   div_den;
  logic [FRAC_BITS-1:0]   quot;

  assign accept = pixel_valid && !pixel_stall;

  // zero counts are raised to one before scoring
  assign tp_cl = (tp == '0) ? CNT_ONE : tp;
  assign fp_cl = (fp == '0) ? CNT_ONE : fp;
  assign fn_cl = (fn == '0) ? CNT_ONE : fn;

  // numerator 2tp, denominator 2tp + fp + fn
  assign div_num = REM_WIDTH'({tp_cl, 1'b0});
  assign div_den = REM_WIDTH'({tp_cl, 1'b0}) + REM_WIDTH'(fp_cl) + REM_WIDTH'(fn_cl);

  msf1_counter u_counter (
    .clk          (clk),
    .rst          (rst),
    .ctl          (cnt_ctl),
    .result_pixel (pixel.result_pixel),
    .target_pixel (pixel.target_pixel),
    .tp           (tp),
    .fp           (fp),
    .fn           (fn)
  );

  msf1_divider u_divider (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (quot)
  );

  // sequencer: counting, latch, divide, write score
  always_ff @(posedge clk) begin
    if (rst) state <= ST_RUN;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_RUN:  if (accept && pixel.last_pixel) state_next = ST_LOAD;
      ST_LOAD: state_next = ST_DIV;
      ST_DIV:  if (div_done) state_next = ST_DONE;
      ST_DONE: if (out_load) state_next = ST_RUN;
      default: state_next = ST_RUN;
    endcase
  end

  always_comb begin
    pixel_stall   = 1'b1;
    cnt_ctl.inc   = 1'b0;
    cnt_ctl.clear = 1'b0;
    div_start     = 1'b0;
    out_load      = 1'b0;
    case (state)
      ST_RUN: begin
        pixel_stall = 1'b0;
        cnt_ctl.inc = accept && (pixel.mask_pixel != 8'd0);
      end
      ST_LOAD: begin
        cnt_ctl.clear = 1'b1;
        div_start     = 1'b1;
      end
      ST_DIV: begin
        pixel_stall = 1'b1;
      end
      ST_DONE: begin
        // wait for the score register to be free
        out_load = !score_valid || !score_stall;
      end
      default: begin
        pixel_stall = 1'b1;
      end
    endcase
  end

  // clamped counts kept while the counters restart
  always_ff @(posedge clk) begin
    if (div_start) begin
      tp_hold <= tp_cl;
      fp_hold <= fp_cl;
      fn_hold <= fn_cl;
    end
  end

  // score register, held while stalled
  always_ff @(posedge clk) begin
    if (out_load) begin
      score.true_pos  <= tp_hold;
      score.false_pos <= fp_hold;
      score.false_neg <= fn_hold;
      score.f1_fixed  <= quot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst)                score_valid <= 1'b0;
    else if (out_load)      score_valid <= 1'b1;
    else if (!score_stall)  score_valid <= 1'b0;
  end

  `MSF1_ASSERT_IMP(a_score_src, clk, rst, $rose(score_valid), ($past(state) == ST_DONE))
  `MSF1_ASSERT_IMP(a_div_stall, clk, rst, (state == ST_DIV || state == ST_LOAD), pixel_stall)
  `MSF1_ASSERT_NXT(a_load_clear, clk, rst, (state == ST_LOAD), (tp == '0 && state == ST_DIV))

endmodule

// ===== bench/msf1_checker.sv =====
// score checker for the masked segmentation f1 score unit: tracks frame counts
// from accepted pixels, predicts each score item and compares it field by field
// depends on msf1_pkg
`timescale 1ns / 100ps
module msf1_checker
  import msf1_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   pixel_valid,
  input  logic   pixel_stall,
  input  pixel_t pixel,
  input  logic   score_valid,
  input  logic   score_stall,
  input  score_t score,
  input  logic   flush,
  output int     fail_count,
  output int     pending,
  output int     scores_seen
);

  logic [COUNT_WIDTH-1:0] tp_run;
  logic [COUNT_WIDTH-1:0] fp_run;
  logic [COUNT_WIDTH-1:0] fn_run;
  score_t                 awaited_scores[$];
  logic                   flushed;

  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    fail_count++;
  endtask

  // saturating counter step
  function automatic logic [COUNT_WIDTH-1:0] bump(input logic [COUNT_WIDTH-1:0] c);
    return (&c) ? c : c + 1'b1;
  endfunction

  function automatic score_t frame_score(input logic [COUNT_WIDTH-1:0] tp,
                                         input logic [COUNT_WIDTH-1:0] fp,
                                         input logic [COUNT_WIDTH-1:0] fn);
    logic [63:0] t;
    logic [63:0] f;
    logic [63:0] n;
    logic [63:0] q;
    score_t      s;
    t = (tp == '0) ? 64'd1 : 64'(tp);
    f = (fp == '0) ? 64'd1 : 64'(fp);
    n = (fn == '0) ? 64'd1 : 64'(fn);
    // exact floor of 2tp * 2^FRAC_BITS / (2tp + fp + fn)
    q = (t << (FRAC_BITS + 1)) / ((t << 1) + f + n);
    s.true_pos  = t[COUNT_WIDTH-1:0];
    s.false_pos = f[COUNT_WIDTH-1:0];
    s.false_neg = n[COUNT_WIDTH-1:0];
    s.f1_fixed  = q[FRAC_BITS-1:0];
    return s;
  endfunction

  task automatic count_pixel(input pixel_t p);
    if (p.mask_pixel != 8'd0) begin
      if (p.result_pixel == PIX_FG && p.target_pixel == PIX_FG) begin
        tp_run = bump(tp_run);
      end else if (p.result_pixel == PIX_FG && p.target_pixel == PIX_BG) begin
        fp_run = bump(fp_run);
      end else if (p.result_pixel == PIX_BG && p.target_pixel == PIX_FG) begin
        fn_run = bump(fn_run);
      end
    end
    if (p.last_pixel) begin
      awaited_scores.push_back(frame_score(tp_run, fp_run, fn_run));
      tp_run = '0;
      fp_run = '0;
      fn_run = '0;
    end
  endtask

  task automatic check_score(input score_t got);
    score_t want;
    if (awaited_scores.size() == 0) begin
      report($sformatf("score item %0d arrived with no frame outstanding", scores_seen));
    end else begin
      want = awaited_scores.pop_front();
      if (got.true_pos !== want.true_pos)
        report($sformatf("score %0d true_pos got %0d expected %0d",
                         scores_seen, got.true_pos, want.true_pos));
      if (got.false_pos !== want.false_pos)
        report($sformatf("score %0d false_pos got %0d expected %0d",
                         scores_seen, got.false_pos, want.false_pos));
      if (got.false_neg !== want.false_neg)
        report($sformatf("score %0d false_neg got %0d expected %0d",
                         scores_seen, got.false_neg, want.false_neg));
      if (got.f1_fixed !== want.f1_fixed)
        report($sformatf("score %0d f1_fixed got %0d expected %0d",
                         scores_seen, got.f1_fixed, want.f1_fixed));
    end
    scores_seen++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      tp_run = '0;
      fp_run = '0;
      fn_run = '0;
      awaited_scores.delete();
      flushed = 1'b0;
      fail_count = 0;
      scores_seen = 0;
    end else begin
      if (score_valid && !score_stall) check_score(score);
      if (pixel_valid && !pixel_stall) count_pixel(pixel);
      if (flush && !flushed) begin
        while (awaited_scores.size() != 0) begin
          void'(awaited_scores.pop_front());
          report("frame score never arrived");
        end
        flushed = 1'b1;
      end
    end
    pending = awaited_scores.size();
  end

endmodule

// ===== bench/testbench.sv =====
// top of the bench for the masked segmentation f1 score unit: drives pixel frames
// and score backpressure, and gives the verdict from the checker's failure count
// depends on msf1_pkg, msf1_checker and the rtl of the unit
`timescale 1ns / 100ps
module testbench;
  import msf1_pkg::*;

  logic   clk         = 1'b0;
  logic   rst         = 1'b1;
  logic   pixel_valid = 1'b0;
  logic   pixel_stall;
  pixel_t pixel       = '0;
  logic   score_valid;
  logic   score_stall = 1'b0;
  score_t score;
  logic   flush       = 1'b0;

  int fail_count;
  int pending;
  int scores_seen;

  // counts kept by the stimulus side
  int pixels_sent = 0;
  int frames_sent = 0;
  // random idling on both channels; off in the quiet stretch and the closing part
  bit gaps_on     = 1'b1;
  int stall_left  = 0;

  masked_segmentation_f1_score_unit u_dut (
    .clk         (clk),
    .rst         (rst),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .pixel       (pixel),
    .score_valid (score_valid),
    .score_stall (score_stall),
    .score       (score)
  );

  msf1_checker u_check (
    .clk         (clk),
    .rst         (rst),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .pixel       (pixel),
    .score_valid (score_valid),
    .score_stall (score_stall),
    .score       (score),
    .flush       (flush),
    .fail_count  (fail_count),
    .pending     (pending),
    .scores_seen (scores_seen)
  );

  always #10 clk = ~clk;

  // hard stop in case the block hangs
  initial begin
    #5ms;
    $display("timeout: block stopped moving items");
    $display("status: fail");
    $finish;
  end

  // score side backpressure: random bursts of stalled cycles
  initial begin
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
      end else if (gaps_on && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 7);
      end
      score_stall <= (stall_left > 0);
    end
  end

  function automatic pixel_t mk(input logic [7:0] m, input logic [7:0] r,
                                input logic [7:0] t, input logic l);
    pixel_t p;
    p.mask_pixel   = m;
    p.result_pixel = r;
    p.target_pixel = t;
    p.last_pixel   = l;
    return p;
  endfunction

  // foreground with the given percentage, otherwise background, sometimes any byte
  function automatic logic [7:0] pick_byte(input int fg_pct, input int noise_pct);
    if ($urandom_range(0, 99) < noise_pct) return 8'($urandom_range(0, 255));
    return ($urandom_range(0, 99) < fg_pct) ? PIX_FG : PIX_BG;
  endfunction

  // entered and left at a falling edge; holds the item until accepted
  task automatic send_pixel(input pixel_t p);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      pixel_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    pixel       <= p;
    pixel_valid <= 1'b1;
    do @(posedge clk); while (pixel_stall);
    pixels_sent++;
    if (p.last_pixel) frames_sent++;
    // quiet stretch in the middle and no idling in the closing part
    gaps_on = (pixels_sent < 350) || (pixels_sent >= 700 && pixels_sent < 850);
    @(negedge clk);
  endtask

  initial begin
    int     len;
    int     res_fg;
    int     tgt_fg;
    int     noise;
    logic   [7:0] m;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // lone masked last pixel: every count clamps to one
    send_pixel(mk(8'd0, PIX_FG, PIX_FG, 1'b1));
    // one of each case, masked and odd values, counted last pixel
    send_pixel(mk(8'd255, PIX_FG, PIX_FG, 1'b0));
    send_pixel(mk(8'd1,   PIX_FG, PIX_BG, 1'b0));
    send_pixel(mk(8'd128, PIX_BG, PIX_FG, 1'b0));
    send_pixel(mk(8'd0,   PIX_FG, PIX_FG, 1'b0));
    send_pixel(mk(8'd255, 8'd1,   PIX_FG, 1'b0));
    send_pixel(mk(8'd255, PIX_FG, 8'd254, 1'b0));
    send_pixel(mk(8'd255, PIX_BG, PIX_BG, 1'b0));
    send_pixel(mk(8'h7f,  PIX_FG, PIX_FG, 1'b0));
    send_pixel(mk(8'd255, PIX_FG, PIX_FG, 1'b1));
    // all true positives: highest score of the directed part
    repeat (5) send_pixel(mk(8'h80, PIX_FG, PIX_FG, 1'b0));
    send_pixel(mk(8'h01, PIX_FG, PIX_FG, 1'b1));
    // errors only: true positive count clamps up from zero
    repeat (2) send_pixel(mk(8'h55, PIX_FG, PIX_BG, 1'b0));
    send_pixel(mk(8'haa, PIX_BG, PIX_FG, 1'b1));
    // last pixel with values that count nothing
    send_pixel(mk(8'hff, 8'haa, 8'h55, 1'b1));

    // random frames: mostly short, a few long; each with its own mix
    while (pixels_sent < 1000) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 30);
      // the final frame ends at the pixel budget
      if (len > 1000 - pixels_sent) len = 1000 - pixels_sent;
      res_fg = $urandom_range(0, 100);
      tgt_fg = $urandom_range(0, 100);
      noise  = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 5);
      for (int i = 0; i < len; i++) begin
        m = ($urandom_range(0, 7) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
        send_pixel(mk(m, pick_byte(res_fg, noise), pick_byte(tgt_fg, noise), i == len - 1));
      end
    end
    pixel_valid <= 1'b0;

    // drain outstanding scores, then let any late item show up
    while (pending != 0) @(negedge clk);
    repeat (3 * (FRAC_BITS + 2)) @(negedge clk);
    flush <= 1'b1;
    repeat (2) @(negedge clk);

    $display("covered %0d pixels in %0d frames, %0d score items compared",
             pixels_sent, frames_sent, scores_seen);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/msf1_pkg.sv
hw/rtl/msf1_counter.sv
hw/rtl/msf1_divider.sv
hw/rtl/masked_segmentation_f1_score_unit.sv
bench/msf1_checker.sv
bench/testbench.sv
